### sv/tds_pkg.sv
// shared types and codes for the tagged deque store
package tds_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_TAIL = 3'd0,
    KIND_PUSH_HEAD = 3'd1,
    KIND_POP_HEAD  = 3'd2,
    KIND_POP_TAIL  = 3'd3,
    KIND_DELETE    = 3'd4,
    KIND_READ      = 3'd5,
    KIND_WRITE     = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_DEL,
    S_DONE
  } state_t;

endpackage

### sv/tagged_deque_store_core.sv
// top level of the tagged deque store
//
//  channel  dir  signals                    payload
//  s_*      in   tvalid tready tdata tuser  tuser kind, tdata value tag position
//  m_*      out  tvalid tready tdata        tdata value tag count removed status
//
// push and write go through exec to done; pop and read add a read wait state, skipped when flagged
// delete by value walks the entries in the delete state, one entry a cycle through the read port
// s_tready is high only while the sequencer is idle
// result waits in the output register; a held result stalls only the next finish
// rst is synchronous, clears the head pointer, count, state and valid; entries are undefined until pushed
module tagged_deque_store_core import tds_pkg::*; #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 16,
  parameter int TAG_WIDTH   = 8,
  localparam int AW       = $clog2(DEPTH),
  localparam int CW       = $clog2(DEPTH + 1),
  localparam int IN_BITS  = VALUE_WIDTH + TAG_WIDTH + AW,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = VALUE_WIDTH + TAG_WIDTH + 2 * CW + STATUS_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // value, tag, position
  input  logic [KIND_W-1:0] s_tuser,   // kind
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // out_value, out_tag, entry_count, removed, status
);

  logic                   start;
  logic                   ready;
  logic                   out_free;
  logic                   res_valid;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [TAG_WIDTH-1:0]   res_tag;
  logic [CW-1:0]          res_count;
  logic [CW-1:0]          res_removed;
  status_t                res_status;

  logic                   wr_en;
  logic                   wr_tag_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_value;
  logic [TAG_WIDTH-1:0]   wr_tag;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic [TAG_WIDTH-1:0]   rd_tag;

  logic [VALUE_WIDTH-1:0] in_value;
  logic [TAG_WIDTH-1:0]   in_tag;
  logic [AW-1:0]          in_pos;

  assign in_value = s_tdata[VALUE_WIDTH-1:0];
  assign in_tag   = s_tdata[VALUE_WIDTH +: TAG_WIDTH];
  assign in_pos   = s_tdata[VALUE_WIDTH+TAG_WIDTH +: AW];

  assign s_tready = ready;
  assign start    = s_tvalid && ready;
  assign out_free = !m_tvalid || m_tready;

  tds_seq #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .in_kind     (s_tuser),
    .in_value    (in_value),
    .in_tag      (in_tag),
    .in_pos      (in_pos),
    .ready       (ready),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res_value   (res_value),
    .res_tag     (res_tag),
    .res_count   (res_count),
    .res_removed (res_removed),
    .res_status  (res_status),
    .wr_en       (wr_en),
    .wr_tag_en   (wr_tag_en),
    .wr_addr     (wr_addr),
    .wr_value    (wr_value),
    .wr_tag      (wr_tag),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_value    (rd_value),
    .rd_tag      (rd_tag)
  );

  tds_mem #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_tag_en (wr_tag_en),
    .wr_addr   (wr_addr),
    .wr_value  (wr_value),
    .wr_tag    (wr_tag),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_value  (rd_value),
    .rd_tag    (rd_tag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      m_tdata <= OUT_W'({res_status, res_removed, res_count, res_tag, res_value});
    end
  end

endmodule

### sv/tds_wrap.sv
// ring address adder, base plus offset modulo depth
module tds_wrap #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic [AW-1:0] base,
  input  logic [AW-1:0] off,
  output logic [AW-1:0] sum
);

  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  logic [AW:0] raw;
  logic [AW:0] wrapped;

  always_comb begin
    raw     = {1'b0, base} + {1'b0, off};
    wrapped = (raw >= DEPTH_W) ? raw - DEPTH_W : raw;
    sum     = wrapped[AW-1:0];
  end

endmodule

### sv/tds_mem.sv
// entry storage, one write port and one registered read port
module tds_mem #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 16,
  parameter int TAG_WIDTH   = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic                   wr_tag_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [VALUE_WIDTH-1:0] wr_value,
  input  logic [TAG_WIDTH-1:0]   wr_tag,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [VALUE_WIDTH-1:0] rd_value,
  output logic [TAG_WIDTH-1:0]   rd_tag
);

  logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
  logic [TAG_WIDTH-1:0]   tag_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[wr_addr] <= wr_value;
    end
    if (wr_tag_en) begin
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_value <= value_mem[rd_addr];
      rd_tag   <= tag_mem[rd_addr];
    end
  end

endmodule

### sv/tds_seq.sv
// operation sequencer: pointers, count, delete compaction walk
module tds_seq import tds_pkg::*; #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 16,
  parameter int TAG_WIDTH   = 8,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic [TAG_WIDTH-1:0]   in_tag,
  input  logic [AW-1:0]          in_pos,
  output logic                   ready,
  input  logic                   out_free,
  output logic                   res_valid,
  output logic [VALUE_WIDTH-1:0] res_value,
  output logic [TAG_WIDTH-1:0]   res_tag,
  output logic [CW-1:0]          res_count,
  output logic [CW-1:0]          res_removed,
  output status_t                res_status,
  output logic                   wr_en,
  output logic                   wr_tag_en,
  output logic [AW-1:0]          wr_addr,
  output logic [VALUE_WIDTH-1:0] wr_value,
  output logic [TAG_WIDTH-1:0]   wr_tag,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  logic [VALUE_WIDTH-1:0] rd_value,
  input  logic [TAG_WIDTH-1:0]   rd_tag
);

  state_t state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;

  logic [KIND_W-1:0]      op_kind;
  logic [VALUE_WIDTH-1:0] op_value;
  logic [TAG_WIDTH-1:0]   op_tag;
  logic [AW-1:0]          op_pos;

  logic [AW-1:0] src, src_next, dst, dst_next;
  logic [CW-1:0] issued, issued_next, kept, kept_next;
  logic          pend, pend_next;

  logic [VALUE_WIDTH-1:0] res_value_next;
  logic [TAG_WIDTH-1:0]   res_tag_next;
  logic [CW-1:0]          res_removed_next;
  status_t                res_status_next;

  logic [AW-1:0] off;
  logic [AW-1:0] addr;
  logic [AW-1:0] src_inc, dst_inc;
  logic [CW-1:0] count_dec;
  logic          is_full, is_empty, out_of_range;

  assign count_dec    = count - CW'(1);
  assign is_full      = (count == CW'(DEPTH));
  assign is_empty     = (count == '0);
  assign out_of_range = (CW'(op_pos) >= count);

  always_comb begin
    case (op_kind)
      KIND_PUSH_TAIL: off = count[AW-1:0];
      KIND_PUSH_HEAD: off = AW'(DEPTH - 1);
      KIND_POP_HEAD:  off = AW'(1);
      KIND_POP_TAIL:  off = count_dec[AW-1:0];
      KIND_READ:      off = op_pos;
      KIND_WRITE:     off = op_pos;
      default:        off = '0;
    endcase
  end

  tds_wrap #(.DEPTH(DEPTH)) u_addr (
    .base (head),
    .off  (off),
    .sum  (addr)
  );

  tds_wrap #(.DEPTH(DEPTH)) u_src_inc (
    .base (src),
    .off  (AW'(1)),
    .sum  (src_inc)
  );

  tds_wrap #(.DEPTH(DEPTH)) u_dst_inc (
    .base (dst),
    .off  (AW'(1)),
    .sum  (dst_inc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_kind  <= in_kind;
      op_value <= in_value;
      op_tag   <= in_tag;
      op_pos   <= in_pos;
    end
    src         <= src_next;
    dst         <= dst_next;
    issued      <= issued_next;
    kept        <= kept_next;
    res_value   <= res_value_next;
    res_tag     <= res_tag_next;
    res_removed <= res_removed_next;
    res_status  <= res_status_next;
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    src_next         = src;
    dst_next         = dst;
    issued_next      = issued;
    kept_next        = kept;
    pend_next        = 1'b0;
    res_value_next   = res_value;
    res_tag_next     = res_tag;
    res_removed_next = res_removed;
    res_status_next  = res_status;
    wr_en            = 1'b0;
    wr_tag_en        = 1'b0;
    wr_addr          = addr;
    wr_value         = op_value;
    wr_tag           = op_tag;
    rd_en            = 1'b0;
    rd_addr          = addr;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_value_next   = '0;
        res_tag_next     = '0;
        res_removed_next = '0;
        res_status_next  = STAT_OK;
        state_next       = S_DONE;
        case (op_kind)
          KIND_PUSH_TAIL: begin
            if (is_full) begin
              res_status_next = STAT_FULL;
            end else begin
              wr_en      = 1'b1;
              wr_tag_en  = 1'b1;
              count_next = count + CW'(1);
            end
          end
          KIND_PUSH_HEAD: begin
            if (is_full) begin
              res_status_next = STAT_FULL;
            end else begin
              wr_en      = 1'b1;
              wr_tag_en  = 1'b1;
              head_next  = addr;
              count_next = count + CW'(1);
            end
          end
          KIND_POP_HEAD: begin
            if (is_empty) begin
              res_status_next = STAT_EMPTY;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = head;
              head_next  = addr;
              count_next = count_dec;
              state_next = S_RDWAIT;
            end
          end
          KIND_POP_TAIL: begin
            if (is_empty) begin
              res_status_next = STAT_EMPTY;
            end else begin
              rd_en      = 1'b1;
              count_next = count_dec;
              state_next = S_RDWAIT;
            end
          end
          KIND_READ: begin
            if (out_of_range) begin
              res_status_next = STAT_RANGE;
            end else begin
              rd_en      = 1'b1;
              state_next = S_RDWAIT;
            end
          end
          KIND_WRITE: begin
            if (out_of_range) begin
              res_status_next = STAT_RANGE;
            end else begin
              wr_en = 1'b1;
            end
          end
          KIND_DELETE: begin
            src_next    = head;
            dst_next    = head;
            issued_next = '0;
            kept_next   = '0;
            state_next  = S_DEL;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_RDWAIT: begin
        res_value_next = rd_value;
        res_tag_next   = rd_tag;
        state_next     = S_DONE;
      end

      S_DEL: begin
        rd_addr = src;
        if (issued != count) begin
          rd_en       = 1'b1;
          src_next    = src_inc;
          issued_next = issued + CW'(1);
          pend_next   = 1'b1;
        end
        if (pend && (rd_value != op_value)) begin
          wr_en     = 1'b1;
          wr_tag_en = 1'b1;
          wr_addr   = dst;
          wr_value  = rd_value;
          wr_tag    = rd_tag;
          dst_next  = dst_inc;
          kept_next = kept + CW'(1);
        end
        if ((issued == count) && !pend) begin
          count_next       = kept;
          res_removed_next = count - kept;
          state_next       = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_count = count;

endmodule

### sv/tds_check.sv
// port checker for the tagged deque store, bound to the top level
module tds_check import tds_pkg::*; #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 16,
  parameter int TAG_WIDTH   = 8,
  localparam int CW       = $clog2(DEPTH + 1),
  localparam int OUT_BITS = VALUE_WIDTH + TAG_WIDTH + 2 * CW + STATUS_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8,
  localparam int CNT_LO   = VALUE_WIDTH + TAG_WIDTH,
  localparam int REM_LO   = CNT_LO + CW,
  localparam int STAT_LO  = REM_LO + CW
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_W-1:0]  m_tdata
);

  logic [VALUE_WIDTH-1:0] o_value;
  logic [TAG_WIDTH-1:0]   o_tag;
  logic [CW-1:0]          o_count;
  logic [CW-1:0]          o_removed;
  logic [STATUS_W-1:0]    o_status;

  assign o_value   = m_tdata[VALUE_WIDTH-1:0];
  assign o_tag     = m_tdata[VALUE_WIDTH +: TAG_WIDTH];
  assign o_count   = m_tdata[CNT_LO +: CW];
  assign o_removed = m_tdata[REM_LO +: CW];
  assign o_status  = m_tdata[STAT_LO +: STATUS_W];

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_count <= CW'(DEPTH)) && (o_removed <= CW'(DEPTH)))
    else $error("entry count or removed beyond depth");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (o_status != STAT_OK)) |->
      (o_value == '0) && (o_tag == '0) && (o_removed == '0))
    else $error("flagged result carries data");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result beat without an item in work");

endmodule

bind tagged_deque_store_core tds_check #(
  .DEPTH       (DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH),
  .TAG_WIDTH   (TAG_WIDTH)
) u_tds_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### bench/testbench.sv
// testbench for tagged_deque_store_core: table-driven and random deque traffic checked beat by beat
`timescale 1ns / 100ps

module testbench;
  import tds_pkg::*;

  localparam int IN_W      = 32;
  localparam int OUT_W     = 40;
  localparam int SLOTS     = 64;
  localparam int GAP_MAX   = 13;
  localparam int HOLD_AT   = 300;
  localparam int HOLD_OFF  = 400;
  localparam int WATCHDOG  = 3000;
  localparam int TAIL_WAIT = 100;
  localparam int PHASES    = 12;
  localparam int PHASE_LEN = 62;
  localparam int DIR_ROWS  = 22;
  localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

  typedef struct packed {
    logic signed [15:0] value;
    logic [7:0]         tag;
    logic [6:0]         count;
    logic [6:0]         removed;
    status_t            status;
  } result_t;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic signed [15:0] value;
    logic [7:0]         tag;
    logic [5:0]         pos;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic [KIND_W-1:0] s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  logic signed [15:0] deq_val [SLOTS];
  logic [7:0]         deq_tag [SLOTS];
  logic [5:0]         deq_head;
  logic [6:0]         deq_fill;

  result_t   awaited [$];
  stim_row_t dir_tab [DIR_ROWS];
  int        mix [3][6] = '{'{40, 70, 78, 84, 87, 95},
                            '{12, 20, 50, 78, 84, 93},
                            '{22, 40, 55, 68, 76, 90}};
  int        mismatches = 0;
  int        quiet = 0;
  bit        send_burst = 1'b0;

  tagged_deque_store_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic result_t deque_step(input logic [KIND_W-1:0] kind,
                                         input logic signed [15:0] value,
                                         input logic [7:0] tag, input logic [5:0] pos);
    result_t    r;
    logic [5:0] slot;
    logic [5:0] src;
    logic [5:0] dst;
    int         kept;
    r = '0;
    r.status = STAT_OK;
    case (kind)
      KIND_PUSH_TAIL, KIND_PUSH_HEAD: begin
        if (deq_fill == 7'(SLOTS)) begin
          r.status = STAT_FULL;
        end else begin
          if (kind == KIND_PUSH_HEAD) begin
            deq_head = deq_head - 6'd1;
            slot = deq_head;
          end else begin
            slot = deq_head + deq_fill[5:0];
          end
          deq_val[slot] = value;
          deq_tag[slot] = tag;
          deq_fill = deq_fill + 7'd1;
        end
      end
      KIND_POP_HEAD, KIND_POP_TAIL: begin
        if (deq_fill == 7'd0) begin
          r.status = STAT_EMPTY;
        end else begin
          if (kind == KIND_POP_HEAD) begin
            slot = deq_head;
            deq_head = deq_head + 6'd1;
          end else begin
            slot = deq_head + deq_fill[5:0] - 6'd1;
          end
          r.value = deq_val[slot];
          r.tag = deq_tag[slot];
          deq_fill = deq_fill - 7'd1;
        end
      end
      KIND_DELETE: begin
        kept = 0;
        for (int i = 0; i < int'(deq_fill); i++) begin
          src = deq_head + 6'(i);
          if (deq_val[src] != value) begin
            dst = deq_head + 6'(kept);
            deq_val[dst] = deq_val[src];
            deq_tag[dst] = deq_tag[src];
            kept++;
          end
        end
        r.removed = deq_fill - 7'(kept);
        deq_fill = 7'(kept);
      end
      KIND_READ, KIND_WRITE: begin
        if ({1'b0, pos} >= deq_fill) begin
          r.status = STAT_RANGE;
        end else begin
          slot = deq_head + pos;
          if (kind == KIND_READ) begin
            r.value = deq_val[slot];
            r.tag = deq_tag[slot];
          end else begin
            deq_val[slot] = value;
          end
        end
      end
      default: ;
    endcase
    r.count = deq_fill;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_value();
    logic signed [15:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = 16'($urandom_range(0, 6));
        v = v - 16'sd3;
      end
      1: v = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic offer(input logic [KIND_W-1:0] kind, input logic signed [15:0] value,
                       input logic [7:0] tag, input logic [5:0] pos,
                       input bit typed, input result_t want);
    int      gap;
    result_t predicted;
    gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, pos, tag, value};
    do @(posedge clk); while (!s_tready);
    predicted = deque_step(kind, value, tag, pos);
    awaited.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // source side
  initial begin
    int                 r;
    int                 mode;
    logic [KIND_W-1:0]  kind;
    logic signed [15:0] value;
    logic [5:0]         pos;
    logic [5:0]         idx;
    result_t            blank;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = KIND_PUSH_TAIL;
    blank    = '0;
    deq_head = '0;
    deq_fill = '0;
    dir_tab = '{
      '{KIND_POP_HEAD,  16'sd0,     8'h00, 6'd0,  1'b1, '{16'sd0,     8'h00, 7'd0, 7'd0, STAT_EMPTY}},
      '{KIND_POP_TAIL,  16'sd0,     8'h00, 6'd0,  1'b1, '{16'sd0,     8'h00, 7'd0, 7'd0, STAT_EMPTY}},
      '{KIND_READ,      16'sd0,     8'h00, 6'd0,  1'b1, '{16'sd0,     8'h00, 7'd0, 7'd0, STAT_RANGE}},
      '{KIND_WRITE,     16'sh7FFF,  8'hFF, 6'd63, 1'b1, '{16'sd0,     8'h00, 7'd0, 7'd0, STAT_RANGE}},
      '{KIND_DELETE,    16'sd0,     8'h00, 6'd0,  1'b1, '{16'sd0,     8'h00, 7'd0, 7'd0, STAT_OK}},
      '{KIND_PUSH_TAIL, 16'sh8000,  8'h00, 6'd0,  1'b1, '{16'sd0,     8'h00, 7'd1, 7'd0, STAT_OK}},
      '{KIND_PUSH_HEAD, 16'sh7FFF,  8'hFF, 6'd63, 1'b1, '{16'sd0,     8'h00, 7'd2, 7'd0, STAT_OK}},
      '{KIND_PUSH_TAIL, -16'sd1,    8'hAA, 6'd0,  1'b1, '{16'sd0,     8'h00, 7'd3, 7'd0, STAT_OK}},
      '{KIND_READ,      16'sd0,     8'h00, 6'd0,  1'b1, '{16'sh7FFF,  8'hFF, 7'd3, 7'd0, STAT_OK}},
      '{KIND_READ,      16'sd0,     8'h00, 6'd2,  1'b1, '{-16'sd1,    8'hAA, 7'd3, 7'd0, STAT_OK}},
      '{KIND_READ,      16'sd0,     8'h00, 6'd3,  1'b1, '{16'sd0,     8'h00, 7'd3, 7'd0, STAT_RANGE}},
      '{KIND_WRITE,     16'sd5,     8'h55, 6'd1,  1'b1, '{16'sd0,     8'h00, 7'd3, 7'd0, STAT_OK}},
      '{KIND_READ,      16'sd0,     8'h00, 6'd1,  1'b1, '{16'sd5,     8'h00, 7'd3, 7'd0, STAT_OK}},
      '{KIND_PUSH_TAIL, 16'sd5,     8'h01, 6'd0,  1'b1, '{16'sd0,     8'h00, 7'd4, 7'd0, STAT_OK}},
      '{KIND_PUSH_HEAD, 16'sd5,     8'h02, 6'd0,  1'b1, '{16'sd0,     8'h00, 7'd5, 7'd0, STAT_OK}},
      '{KIND_DELETE,    16'sd5,     8'h00, 6'd0,  1'b1, '{16'sd0,     8'h00, 7'd2, 7'd3, STAT_OK}},
      '{KIND_DELETE,    16'sd7,     8'h00, 6'd0,  1'b1, '{16'sd0,     8'h00, 7'd2, 7'd0, STAT_OK}},
      '{KIND_POP_TAIL,  16'sd0,     8'h00, 6'd0,  1'b1, '{-16'sd1,    8'hAA, 7'd1, 7'd0, STAT_OK}},
      '{KIND_POP_HEAD,  16'sd0,     8'h00, 6'd0,  1'b1, '{16'sh7FFF,  8'hFF, 7'd0, 7'd0, STAT_OK}},
      '{KIND_SPARE,     16'sh7FFF,  8'hFF, 6'd63, 1'b1, '{16'sd0,     8'h00, 7'd0, 7'd0, STAT_OK}},
      '{KIND_PUSH_HEAD, 16'sh1234,  8'h3C, 6'd0,  1'b0, '{16'sd0,     8'h00, 7'd0, 7'd0, STAT_OK}},
      '{KIND_POP_TAIL,  16'sd0,     8'h00, 6'd0,  1'b0, '{16'sd0,     8'h00, 7'd0, 7'd0, STAT_OK}}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      offer(dir_tab[i].kind, dir_tab[i].value, dir_tab[i].tag, dir_tab[i].pos,
            dir_tab[i].typed, dir_tab[i].want);

    for (int p = 0; p < PHASES; p++) begin
      mode = (p % 4 < 2) ? 0 : ((p % 4 == 2) ? 1 : 2);
      send_burst = (p % 3 == 1);
      if (p == 6) begin
        // let the result side drain completely before going on
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited.size() != 0) @(posedge clk);
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        kind = KIND_WRITE;
        for (int k = 5; k >= 0; k--)
          if (r < mix[mode][k]) kind = KIND_W'(k);
        value = pick_value();
        if (kind == KIND_DELETE && deq_fill != 0 && $urandom_range(0, 9) < 6) begin
          idx = deq_head + 6'($urandom_range(0, int'(deq_fill) - 1));
          value = deq_val[idx];
        end
        if (deq_fill != 0 && $urandom_range(0, 4) != 0)
          pos = 6'($urandom_range(0, int'(deq_fill) - 1));
        else
          pos = 6'($urandom_range(0, 63));
        offer(kind, value, 8'($urandom), pos, 1'b0, blank);
      end
    end

    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // result side
  initial begin
    int      stall;
    int      beats;
    bit      burst;
    result_t want;
    m_tready = 1'b0;
    beats = 0;
    burst = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (beats % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      stall = (beats == HOLD_AT) ? HOLD_OFF : (burst ? 0 : $urandom_range(0, GAP_MAX));
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      beats++;
      if (awaited.size() == 0) begin
        $error("result beat with nothing outstanding: %h", m_tdata);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        check_field("out_value", want.value, $signed(m_tdata[15:0]));
        check_field("out_tag", {24'd0, want.tag}, {24'd0, m_tdata[23:16]});
        check_field("entry_count", {25'd0, want.count}, {25'd0, m_tdata[30:24]});
        check_field("removed", {25'd0, want.removed}, {25'd0, m_tdata[37:31]});
        check_field("status", {30'd0, want.status}, {30'd0, m_tdata[39:38]});
      end
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

### filelist.f
sv/tds_pkg.sv
sv/tds_wrap.sv
sv/tds_mem.sv
sv/tds_seq.sv
sv/tagged_deque_store_core.sv
sv/tds_check.sv
bench/testbench.sv
